@@ rtl/gss_pkg.sv @@
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants of the gapped substring search block.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int unsigned NeedleMax  = 16;
  localparam int unsigned CellIdxW   = $clog2(NeedleMax);
  localparam int unsigned LenW       = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CharsW     = 64;
  localparam int unsigned CountW     = 17;
  localparam int unsigned IndexW     = 16;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 64;

  // register indexes, taken from paddr[3]
  localparam logic RegNeedleLength = 1'b0;
  localparam logic RegNeedleChars  = 1'b1;

  // control that every cell of the window sees
  typedef struct packed {
    logic            shift;
    logic            clear;
    logic [LenW-1:0] eff_len;
  } chain_ctrl_t;

endpackage

@@ rtl/gss_cell.sv @@
// ----------------------------------------------------------------------------
// gss_cell
// One window byte: holds it, passes it on to the next cell, and checks it
// against the needle character that falls on its position.
// ----------------------------------------------------------------------------
module gss_cell (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  gss_pkg::chain_ctrl_t                         ctrl_i,
  input  logic [gss_pkg::CellIdxW-1:0]                 cell_idx_i,
  input  logic [gss_pkg::CharsW-1:0]                   needle_i,
  input  logic [gss_pkg::ByteW-1:0]                    byte_i,
  output logic [gss_pkg::ByteW-1:0]                    byte_o,
  output logic                                         ok_o
);

  logic [gss_pkg::ByteW-1:0] byte_q, byte_d, next_byte;
  logic [gss_pkg::LenW:0]    pos;
  logic                      active;
  logic [gss_pkg::ByteW-1:0] want;

  // window content after this transaction shifts in
  assign next_byte = ctrl_i.shift ? byte_i : byte_q;
  assign byte_d    = ctrl_i.clear ? '0 : next_byte;

  // needle position that lands on this cell
  assign pos    = {1'b0, ctrl_i.eff_len} - (gss_pkg::LenW+1)'(1)
                - {{(gss_pkg::LenW+1-gss_pkg::CellIdxW){1'b0}}, cell_idx_i};
  assign active = ({1'b0, cell_idx_i} < ctrl_i.eff_len) && !pos[0];
  assign want   = needle_i[{pos[3:1], 3'b000} +: gss_pkg::ByteW];
  assign ok_o   = !active || (next_byte == want);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

@@ rtl/gapped_substring_search.sv @@
// ----------------------------------------------------------------------------
// gapped_substring_search
// Streams a text and reports the first start of a needle with don't-care
// odd positions.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock and keeps the last 16 in a chain of
// cells, each comparing its byte with the needle character at its position,
// so an item enters every cycle at full rate. Only even needle positions are
// compared. On the transaction marked is_last one result comes out in the next
// cycle from an output register (found, and the earliest start or 0), and the
// search state clears for the next text. Input stalls only when a last byte
// arrives while the previous result is still held. Needle length 0 counts as
// 1 and lengths above 16 as 16. The needle must be written through APB (length
// at 0x0, even characters at 0x8) while the block is idle; it is not enforced.
module gapped_substring_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            is_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [15:0]                     match_start_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gss_pkg::ApbAddrW-1:0]    paddr,
  input  logic [gss_pkg::ApbDataW-1:0]    pwdata,
  output logic [gss_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  logic [gss_pkg::LenW-1:0]   needle_len_q;
  logic [gss_pkg::CharsW-1:0] needle_chars_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_len_q   <= gss_pkg::LenW'(1);
      needle_chars_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        gss_pkg::RegNeedleLength: needle_len_q   <= pwdata[gss_pkg::LenW-1:0];
        gss_pkg::RegNeedleChars:  needle_chars_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      gss_pkg::RegNeedleLength:
        prdata = {{(gss_pkg::ApbDataW-gss_pkg::LenW){1'b0}}, needle_len_q};
      gss_pkg::RegNeedleChars: prdata = needle_chars_q;
      default: prdata = '0;
    endcase
  end

  logic [gss_pkg::LenW-1:0] eff_len;
  always_comb begin
    if (needle_len_q == '0) begin
      eff_len = gss_pkg::LenW'(1);
    end else if (needle_len_q > gss_pkg::LenW'(gss_pkg::NeedleMax)) begin
      eff_len = gss_pkg::LenW'(gss_pkg::NeedleMax);
    end else begin
      eff_len = needle_len_q;
    end
  end

  // handshake
  logic in_acc, out_free;
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = out_free || !is_last_i;
  assign in_acc     = in_valid_i && in_ready_o;

  logic [gss_pkg::CountW-1:0] bytes_seen_q, bytes_seen_d;
  logic                       have_q, have_d;
  logic [gss_pkg::IndexW-1:0] first_idx_q, first_idx_d;
  logic                       in_text;

  // bytes past the text limit are dropped
  assign in_text = !bytes_seen_q[gss_pkg::CountW-1];

  gss_pkg::chain_ctrl_t ctrl;
  assign ctrl.shift   = in_acc && in_text;
  assign ctrl.clear   = in_acc && is_last_i;
  assign ctrl.eff_len = eff_len;

  logic [gss_pkg::ByteW-1:0] chain [gss_pkg::NeedleMax+1];
  logic [gss_pkg::NeedleMax-1:0] cell_ok;

  assign chain[0] = text_byte_i;

  for (genvar g = 0; g < gss_pkg::NeedleMax; g++) begin : g_cell
    gss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cell_idx_i (gss_pkg::CellIdxW'(g)),
      .needle_i   (needle_chars_q),
      .byte_i     (chain[g]),
      .byte_o     (chain[g+1]),
      .ok_o       (cell_ok[g])
    );
  end

  logic [gss_pkg::CountW-1:0] seen_inc;
  logic [gss_pkg::CountW-1:0] start_pos;
  logic                       hit;
  logic                       have_now;
  logic [gss_pkg::IndexW-1:0] idx_now;

  assign seen_inc  = bytes_seen_q + gss_pkg::CountW'(1);
  assign start_pos = seen_inc - {{(gss_pkg::CountW-gss_pkg::LenW){1'b0}}, eff_len};
  assign hit = ctrl.shift && !have_q && &cell_ok
            && (seen_inc >= {{(gss_pkg::CountW-gss_pkg::LenW){1'b0}}, eff_len});
  assign have_now = have_q || hit;
  assign idx_now  = hit ? start_pos[gss_pkg::IndexW-1:0] : first_idx_q;

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    have_d       = have_q;
    first_idx_d  = first_idx_q;
    if (ctrl.clear) begin
      bytes_seen_d = '0;
      have_d       = 1'b0;
      first_idx_d  = '0;
    end else if (ctrl.shift) begin
      bytes_seen_d = seen_inc;
      have_d       = have_now;
      first_idx_d  = idx_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      have_q       <= 1'b0;
      first_idx_q  <= '0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      have_q       <= have_d;
      first_idx_q  <= first_idx_d;
    end
  end

  // result register
  logic        out_valid_q, out_valid_d;
  logic        found_q;
  logic [15:0] match_start_q;

  assign out_valid_d = ctrl.clear ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      found_q       <= have_now;
      match_start_q <= have_now ? idx_now : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_start_o = match_start_q;

  // checks
  a_nofind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_start_o == '0)
    else $error("match_start nonzero without a match");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last_i |=> bytes_seen_q == '0 && !have_q && out_valid_o)
    else $error("search state not cleared after last byte");

  a_match_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q && !(in_acc && is_last_i) |=> have_q && $stable(first_idx_q))
    else $error("first match lost before end of text");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_seen_q[gss_pkg::CountW-1] |-> bytes_seen_q[gss_pkg::CountW-2:0] == '0)
    else $error("byte count beyond text limit");

endmodule

@@ tb/gapped_substring_search_tb.sv @@
// ----------------------------------------------------------------------------
// gapped_substring_search_tb
// Streams texts through the search block and checks found / match_start
// against a scoreboard that tracks the window, byte count and first match.
// Covers directed edge cases and random texts with planted needles under
// several idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gapped_substring_search_tb;

  localparam int unsigned TextLimit  = 65536;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainWait  = 4;

  localparam logic [gss_pkg::ApbAddrW-1:0] AddrLength = {gss_pkg::RegNeedleLength, 3'b000};
  localparam logic [gss_pkg::ApbAddrW-1:0] AddrChars  = {gss_pkg::RegNeedleChars, 3'b000};

  typedef struct packed {
    logic                       found;
    logic [gss_pkg::IndexW-1:0] start;
  } search_result_t;

  class match_board;
    logic [gss_pkg::LenW-1:0]   needle_len = 1;
    logic [gss_pkg::CharsW-1:0] needle_chars = '0;
    logic [gss_pkg::ByteW-1:0]  window [gss_pkg::NeedleMax];
    logic [gss_pkg::CountW-1:0] seen;
    logic                       hit;
    logic [gss_pkg::IndexW-1:0] hit_at;
    search_result_t             expected_matches [$];
    int                         errors;
    int                         texts;
    int                         texts_hit;
    longint                     bytes_taken;

    function new();
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      seen   = '0;
      hit    = 1'b0;
      hit_at = '0;
    endfunction

    function int unsigned eff_len();
      if (needle_len == 0) return 1;
      if (needle_len > gss_pkg::NeedleMax) return gss_pkg::NeedleMax;
      return needle_len;
    endfunction

    function bit window_hits(int unsigned len);
      for (int unsigned p = 0; p < len; p += 2) begin
        if (window[len - 1 - p] != needle_chars[8*(p/2) +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [gss_pkg::ByteW-1:0] b, logic last);
      int unsigned len;
      search_result_t res;
      len = eff_len();
      bytes_taken++;
      // bytes past the search limit are dropped, count saturates
      if (seen < TextLimit) begin
        for (int i = gss_pkg::NeedleMax - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (!hit && seen + 1 >= len && window_hits(len)) begin
          hit    = 1'b1;
          hit_at = gss_pkg::IndexW'(seen + 1 - len);
        end
        seen = seen + 1'b1;
      end
      if (last) begin
        res.found = hit;
        res.start = hit ? hit_at : '0;
        expected_matches.push_back(res);
        texts++;
        if (hit) texts_hit++;
        clear_text();
      end
    endfunction

    task report(string what);
      errors++;
      // keep the log short when something is badly off
      if (errors <= 20) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic found, logic [gss_pkg::IndexW-1:0] start);
      search_result_t want;
      if (expected_matches.size() == 0) begin
        report($sformatf("result found=%0b start=%0d with no text pending", found, start));
      end else begin
        want = expected_matches.pop_front();
        if (found !== want.found)
          report($sformatf("found %0b, expected %0b", found, want.found));
        if (start !== want.start)
          report($sformatf("match_start %0d, expected %0d", start, want.start));
      end
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [gss_pkg::ByteW-1:0]    text_byte_i;
  logic                         is_last_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         found_o;
  logic [gss_pkg::IndexW-1:0]   match_start_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [gss_pkg::ApbAddrW-1:0] paddr;
  logic [gss_pkg::ApbDataW-1:0] pwdata;
  logic [gss_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  match_board sb = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  gapped_substring_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_start_o (match_start_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(text_byte_i, is_last_i);
      if (out_valid_o && out_ready_i) sb.check_result(found_o, match_start_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no progress for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task apb_write(input logic [gss_pkg::ApbAddrW-1:0] addr,
                 input logic [gss_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr[3] == gss_pkg::RegNeedleChars) sb.needle_chars = data[gss_pkg::CharsW-1:0];
    else sb.needle_len = data[gss_pkg::LenW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus returns to idle between transfers
    @(posedge clk_i);
  endtask

  task send_byte(input logic [gss_pkg::ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    is_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task send_text(input logic [gss_pkg::ByteW-1:0] txt [$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  // block must be idle before a register write
  task wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_matches.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [gss_pkg::ByteW-1:0] nz_byte();
    return gss_pkg::ByteW'($urandom_range(1, 255));
  endfunction

  // random text, in most texts half of the bytes are needle characters so partial hits are common
  task automatic random_text(output int unsigned n);
    logic [gss_pkg::ByteW-1:0] txt [$];
    int unsigned len, pos;
    bit noise;
    len   = sb.eff_len();
    n     = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
    noise = ($urandom_range(99) < 15);
    for (int i = 0; i < n; i++) begin
      if (!noise && $urandom_range(1))
        txt.push_back(sb.needle_chars[8*$urandom_range(7) +: 8]);
      else
        txt.push_back(nz_byte());
    end
    if (!noise && n >= len && $urandom_range(99) < 65) begin
      pos = $urandom_range(0, n - len);
      for (int unsigned p = 0; p < len; p += 2) txt[pos + p] = sb.needle_chars[8*(p/2) +: 8];
    end
    send_text(txt);
  endtask

  initial begin
    logic [gss_pkg::ByteW-1:0] txt [$];
    logic [gss_pkg::CharsW-1:0] chars;
    int unsigned seg_len [16];
    int unsigned items, n;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    text_byte_i = '0;
    is_last_i   = 1'b0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length counts as one character
    apb_write(AddrLength, 64'd0);
    apb_write(AddrChars, 64'h41);
    send_text('{8'h41});
    send_text('{8'h42, 8'h41});
    wait_drained();

    // overlong length saturates to 16, extreme bytes at even positions
    apb_write(AddrLength, 64'd31);
    apb_write(AddrChars, 64'h01FF_01FF_01FF_01FF);
    txt = {};
    for (int p = 0; p < 16; p++) txt.push_back((p % 2) ? nz_byte() : ((p % 4) ? 8'h01 : 8'hFF));
    send_text(txt);
    wait_drained();

    // needle longer than the text
    apb_write(AddrLength, 64'd5);
    send_text('{8'hFF, 8'h55, 8'h01, 8'hAA});
    wait_drained();

    // zero bytes compare like any other byte
    apb_write(AddrLength, 64'd3);
    apb_write(AddrChars, 64'h0);
    send_text('{8'h00, 8'hFF, 8'h00});
    wait_drained();

    seg_len = '{1, 16, 0, 31, 2, 7, 15, 17, 3, 4, 9, 12, 5, 6, 8, 11};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        for (int k = 0; k < 8; k++) chars[8*k +: 8] = nz_byte();
        if (seg == 3) chars = {8{chars[7:0]}};
        if (phase == 3 && seg == 0) chars = '1;
        apb_write(AddrLength, gss_pkg::ApbDataW'(seg_len[4*phase + seg]));
        apb_write(AddrChars, chars);
        items = 0;
        while (items < 100) begin
          random_text(n);
          items += n;
        end
        wait_drained();
      end
    end

    repeat (8) @(posedge clk_i);
    while (sb.expected_matches.size() != 0) begin
      void'(sb.expected_matches.pop_front());
      sb.report("expected result never arrived");
    end
    $display("searched %0d texts (%0d bytes), %0d of them with a match",
             sb.texts, sb.bytes_taken, sb.texts_hit);
    $display("needle lengths 0..31 under four idle/stall mixes, plus directed corner texts");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
